// File: design/isim_pkg.sv
// ---------------------------------------------------------------------------
// isim_pkg: shared types and constants for the interval set insert/merge block
// Word layouts for commands and results, register indexes and sizes.
// ---------------------------------------------------------------------------
package isim_pkg;

	localparam int TIME_W        = 31;
	localparam int ENTRY_W       = 2 * TIME_W;
	localparam int TOTAL_W       = 7;
	localparam int MAX_INTERVALS = 64;
	localparam int CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_QUERY_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_END   = 2'd1;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_CLEAR  = 1'b1;

	typedef logic [TIME_W-1:0] time_t;

	typedef struct packed {
		logic  req_type;
		time_t start_time;
		time_t end_time;
	} cmd_t;

	typedef struct packed {
		time_t              merged_start;
		time_t              merged_end;
		logic [TOTAL_W-1:0] entry_total;
		logic               window_covered;
		logic               overflow;
	} result_t;

	typedef struct packed {
		time_t query_start;
		time_t query_end;
	} query_t;

endpackage

// File: design/isim_ram.sv
// ---------------------------------------------------------------------------
// isim_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module isim_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/isim_core.sv
// ---------------------------------------------------------------------------
// isim_core: sequencer for clear, insert, merge and coverage passes
// Walks the entry RAM one word per cycle, shifts or compacts in place.
// ---------------------------------------------------------------------------
module isim_core #(
	parameter int MAX_INTERVALS = isim_pkg::MAX_INTERVALS,
	localparam int IW = $clog2(MAX_INTERVALS),
	localparam int CW = $clog2(MAX_INTERVALS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  isim_pkg::cmd_t                cmd,
	input  isim_pkg::query_t              query,
	output logic                          done,
	output isim_pkg::result_t             result,
	output logic                          ram_we,
	output logic [IW-1:0]                 ram_waddr,
	output logic [isim_pkg::ENTRY_W-1:0]  ram_wdata,
	output logic [IW-1:0]                 ram_raddr,
	input  logic [isim_pkg::ENTRY_W-1:0]  ram_rdata
);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_SCAN    = 8'b0000_0010,
		ST_MSCAN   = 8'b0000_0100,
		ST_SHUP    = 8'b0000_1000,
		ST_COMPACT = 8'b0001_0000,
		ST_WRITE   = 8'b0010_0000,
		ST_COVER   = 8'b0100_0000,
		ST_DONE    = 8'b1000_0000
	} state_t;

	localparam logic [CW-1:0] FULL = CW'(MAX_INTERVALS);

	state_t             state_q;
	logic [CW-1:0]      idx_q, pos_q, rem_q, count_q, rd_idx, wr_idx;
	logic               rv_q, inc_q, ovf_q, cov_q;
	isim_pkg::time_t    s_q, e_q, res_s_q, res_e_q, last_end_q;
	isim_pkg::time_t    ent_s, ent_e;
	logic               last_idx, full;

	assign ent_s    = ram_rdata[isim_pkg::ENTRY_W-1:isim_pkg::TIME_W];
	assign ent_e    = ram_rdata[isim_pkg::TIME_W-1:0];
	assign last_idx = (idx_q + CW'(1)) == count_q;
	assign full     = count_q == FULL;
	assign busy     = state_q != ST_IDLE;
	assign done     = state_q == ST_DONE;

	// read one ahead while the current word is in use
	always_comb begin
		case (state_q)
			ST_SCAN, ST_MSCAN, ST_COMPACT, ST_COVER: rd_idx = rv_q ? idx_q + CW'(1) : idx_q;
			ST_SHUP: rd_idx = rv_q ? idx_q - CW'(1) : idx_q;
			default: rd_idx = idx_q;
		endcase
	end
	assign ram_raddr = rd_idx[IW-1:0];

	always_comb begin
		ram_we    = 1'b0;
		wr_idx    = pos_q;
		ram_wdata = ram_rdata;
		case (state_q)
			ST_WRITE: begin
				ram_we    = 1'b1;
				ram_wdata = {res_s_q, res_e_q};
			end
			ST_SHUP: begin
				ram_we = rv_q;
				wr_idx = idx_q + CW'(1);
			end
			ST_COMPACT: begin
				ram_we = rv_q;
				wr_idx = idx_q - rem_q;
			end
			default: ram_we = 1'b0;
		endcase
	end
	assign ram_waddr = wr_idx[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			cov_q   <= 1'b0;
			rv_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						rv_q  <= 1'b0;
						idx_q <= '0;
						ovf_q <= 1'b0;
						rem_q <= '0;
						inc_q <= 1'b0;
						if (cmd.req_type == isim_pkg::REQ_CLEAR) begin
							count_q <= '0;
							cov_q   <= 1'b0;
							res_s_q <= '0;
							res_e_q <= '0;
							state_q <= ST_DONE;
						end else begin
							s_q     <= cmd.start_time;
							e_q     <= cmd.end_time;
							res_s_q <= cmd.start_time;
							res_e_q <= cmd.end_time;
							if (count_q == '0) begin
								pos_q   <= '0;
								inc_q   <= 1'b1;
								state_q <= ST_WRITE;
							end else begin
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					if (!rv_q) begin
						rv_q <= 1'b1;
					end else if (e_q < ent_s) begin
						pos_q <= idx_q;
						rv_q  <= 1'b0;
						if (full) begin
							ovf_q   <= 1'b1;
							idx_q   <= '0;
							state_q <= ST_COVER;
						end else begin
							inc_q   <= 1'b1;
							idx_q   <= count_q - CW'(1);
							state_q <= ST_SHUP;
						end
					end else if (s_q <= ent_e) begin
						pos_q      <= idx_q;
						res_s_q    <= (s_q < ent_s) ? s_q : ent_s;
						last_end_q <= ent_e;
						if (last_idx) begin
							res_e_q <= (e_q > ent_e) ? e_q : ent_e;
							state_q <= ST_WRITE;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= ST_MSCAN;
						end
					end else if (last_idx) begin
						pos_q <= count_q;
						rv_q  <= 1'b0;
						idx_q <= '0;
						if (full) begin
							ovf_q   <= 1'b1;
							state_q <= ST_COVER;
						end else begin
							inc_q   <= 1'b1;
							state_q <= ST_WRITE;
						end
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_MSCAN: begin
					if (!rv_q) begin
						rv_q <= 1'b1;
					end else if (e_q >= ent_s) begin
						last_end_q <= ent_e;
						if (last_idx) begin
							res_e_q <= (e_q > ent_e) ? e_q : ent_e;
							rem_q   <= count_q - pos_q - CW'(1);
							state_q <= ST_WRITE;
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end else begin
						res_e_q <= (e_q > last_end_q) ? e_q : last_end_q;
						rem_q   <= idx_q - pos_q - CW'(1);
						rv_q    <= 1'b0;
						if (idx_q == pos_q + CW'(1)) begin
							state_q <= ST_WRITE;
						end else begin
							state_q <= ST_COMPACT;
						end
					end
				end
				ST_SHUP: begin
					if (!rv_q) begin
						rv_q <= 1'b1;
					end else if (idx_q == pos_q) begin
						rv_q    <= 1'b0;
						state_q <= ST_WRITE;
					end else begin
						idx_q <= idx_q - CW'(1);
					end
				end
				ST_COMPACT: begin
					if (!rv_q) begin
						rv_q <= 1'b1;
					end else if (last_idx) begin
						rv_q    <= 1'b0;
						state_q <= ST_WRITE;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_WRITE: begin
					count_q <= count_q + CW'(inc_q) - rem_q;
					idx_q   <= '0;
					rv_q    <= 1'b0;
					state_q <= ST_COVER;
				end
				ST_COVER: begin
					if (count_q == '0) begin
						state_q <= ST_DONE;
					end else if (!rv_q) begin
						rv_q <= 1'b1;
					end else begin
						if (ent_s <= query.query_start && ent_e >= query.query_end) begin
							cov_q <= 1'b1;
						end
						if (last_idx) begin
							rv_q    <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.merged_start   = res_s_q;
	assign result.merged_end     = res_e_q;
	assign result.entry_total    = isim_pkg::TOTAL_W'(count_q);
	assign result.window_covered = cov_q;
	assign result.overflow       = ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL) else $error("entry count beyond table size");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("block still busy after result");
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && ovf_q |-> full) else $error("overflow without full table");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !ram_we) else $error("RAM write while idle");

endmodule

// File: design/interval_set_insert_merge.sv
// ---------------------------------------------------------------------------
// interval_set_insert_merge: sorted interval set with insert and merge
// Keeps disjoint closed intervals in RAM, merges overlapping inserts and
// tracks whether any entry has covered the query window.
// ---------------------------------------------------------------------------
//  channel   | handshake               | word
//  ----------+-------------------------+-----------------------------------
//  command   | start / busy            | cmd    : req_type, start, end
//  result    | done (one-cycle strobe) | result : merged interval, total,
//            |                         |          covered flag, overflow
//  config    | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Sequence: a clear goes straight to the result. An insert primes one RAM
// read and then walks one entry per cycle: the scan with any merge run, the
// shift-up or compaction sweep (which primes its own read first), the write
// of the new or merged entry and a coverage pass over every stored entry.
// The entry RAM has a single read port. Reset clears count and flag at
// once; no sweep.
// The receiver cannot stall: each result is shown for one cycle only.
// ---------------------------------------------------------------------------
module interval_set_insert_merge #(
	parameter int MAX_INTERVALS = isim_pkg::MAX_INTERVALS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  isim_pkg::cmd_t                  cmd,
	output logic                            done,
	output isim_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [isim_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  isim_pkg::time_t                 cfg_data
);

	localparam int IW = $clog2(MAX_INTERVALS);

	isim_pkg::query_t              query_q;
	logic                          ram_we;
	logic [IW-1:0]                 ram_waddr, ram_raddr;
	logic [isim_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;

	// the user must write config only while idle; not enforced here, so take them every cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				isim_pkg::REG_QUERY_START: query_q.query_start <= cfg_data;
				isim_pkg::REG_QUERY_END:   query_q.query_end   <= cfg_data;
				default: query_q <= query_q; // drop writes beyond the map
			endcase
		end
	end

	// entry store: start in the upper half, end in the lower half
	isim_ram #(
		.WIDTH (isim_pkg::ENTRY_W),
		.DEPTH (MAX_INTERVALS)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	isim_core #(
		.MAX_INTERVALS (MAX_INTERVALS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.query     (query_q),
		.done      (done),
		.result    (result),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

endmodule

// File: tb/tb_interval_set_insert_merge.sv
// ---------------------------------------------------------------------------
// tb_interval_set_insert_merge: self-checking bench for the interval set
// Drives insert and clear words through start/busy, predicts each result
// word from a behavioural copy of the sorted interval table and compares
// every field of every done strobe. Query window registers are rewritten
// between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb_interval_set_insert_merge;
	timeunit 1ns;
	timeprecision 1ps;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	isim_pkg::cmd_t                 cmd;
	logic                           done;
	isim_pkg::result_t              result;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [isim_pkg::CFG_IDX_W-1:0] cfg_index;
	isim_pkg::time_t                cfg_data;

	interval_set_insert_merge uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow of the block's table and registers, advanced as words are accepted
	isim_pkg::time_t   shadow_lo [isim_pkg::MAX_INTERVALS];
	isim_pkg::time_t   shadow_hi [isim_pkg::MAX_INTERVALS];
	int                shadow_count;
	logic              shadow_covered;
	isim_pkg::time_t   win_start;
	isim_pkg::time_t   win_end;

	isim_pkg::cmd_t    pending_cmds[$];
	isim_pkg::result_t expected_results[$];
	int                mismatch_count;
	int                gap_pct;
	logic              hold_sender;

	// Work out the result word for one command and update the shadow table
	function automatic isim_pkg::result_t predict_result(isim_pkg::cmd_t c);
		isim_pkg::result_t r;
		int                i;
		int                j;
		int                k;
		int                removed;
		int                pos;
		bit                handled;
		isim_pkg::time_t   lo;
		isim_pkg::time_t   hi;
		r = '0;
		if (c.req_type == isim_pkg::REQ_CLEAR) begin
			shadow_count   = 0;
			shadow_covered = 1'b0;
			return r;
		end
		r.merged_start = c.start_time;
		r.merged_end   = c.end_time;
		handled = 1'b0;
		pos = shadow_count;
		for (i = 0; i < shadow_count && !handled; i++) begin
			if (c.end_time < shadow_lo[i]) begin
				pos = i;
				break;
			end else if (c.start_time <= shadow_hi[i]) begin
				// Absorb every later entry whose start the new end reaches
				j = i + 1;
				while (j < shadow_count && c.end_time >= shadow_lo[j])
					j++;
				lo = (c.start_time < shadow_lo[i]) ? c.start_time : shadow_lo[i];
				hi = (c.end_time > shadow_hi[j-1]) ? c.end_time : shadow_hi[j-1];
				removed = j - i - 1;
				for (k = i + 1; k + removed < shadow_count; k++) begin
					shadow_lo[k] = shadow_lo[k+removed];
					shadow_hi[k] = shadow_hi[k+removed];
				end
				shadow_count -= removed;
				shadow_lo[i] = lo;
				shadow_hi[i] = hi;
				r.merged_start = lo;
				r.merged_end   = hi;
				handled = 1'b1;
			end
		end
		if (!handled) begin
			if (shadow_count >= isim_pkg::MAX_INTERVALS) begin
				r.overflow = 1'b1;
			end else begin
				for (k = shadow_count; k > pos; k--) begin
					shadow_lo[k] = shadow_lo[k-1];
					shadow_hi[k] = shadow_hi[k-1];
				end
				shadow_lo[pos] = c.start_time;
				shadow_hi[pos] = c.end_time;
				shadow_count++;
			end
		end
		for (i = 0; i < shadow_count; i++)
			if (shadow_lo[i] <= win_start && shadow_hi[i] >= win_end)
				shadow_covered = 1'b1;
		r.entry_total    = shadow_count[isim_pkg::TOTAL_W-1:0];
		r.window_covered = shadow_covered;
		return r;
	endfunction

	function automatic isim_pkg::cmd_t make_insert(isim_pkg::time_t s, isim_pkg::time_t e);
		isim_pkg::cmd_t c;
		c.req_type   = isim_pkg::REQ_INSERT;
		c.start_time = s;
		c.end_time   = e;
		return c;
	endfunction

	function automatic isim_pkg::cmd_t make_clear();
		isim_pkg::cmd_t c;
		c.req_type   = isim_pkg::REQ_CLEAR;
		c.start_time = isim_pkg::time_t'($urandom);
		c.end_time   = isim_pkg::time_t'($urandom);
		return c;
	endfunction

	// Add one word at the tail of the pending queue
	function automatic void queue_cmd(isim_pkg::cmd_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	// Random insert: mostly short intervals in a small span so they merge
	// and collide, sometimes full-range values or single points, now and then reversed
	function automatic isim_pkg::cmd_t random_insert();
		isim_pkg::time_t s;
		isim_pkg::time_t e;
		int              sel;
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			s = isim_pkg::time_t'($urandom_range(0, 3000));
			e = s + isim_pkg::time_t'($urandom_range(0, 60));
		end else if (sel < 85) begin
			s = isim_pkg::time_t'($urandom);
			e = isim_pkg::time_t'($urandom);
			if (e < s && $urandom_range(0, 3) != 0) begin
				s ^= e; e ^= s; s ^= e;
			end
		end else if (sel < 95) begin
			s = isim_pkg::time_t'($urandom_range(0, 200));
			e = s;
		end else begin
			e = isim_pkg::time_t'($urandom_range(0, 3000));
			s = e + isim_pkg::time_t'($urandom_range(1, 20));
		end
		return make_insert(s, e);
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

	// Driver: hand the oldest pending word to the block, idling at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd   <= '0;
		end else begin
			if (start && !busy) begin
				// Word accepted at this edge: predict it now and drop it
				expected_results.insert(expected_results.size(), predict_result(cmd));
				void'(pending_cmds.pop_front());
			end
			if (start && busy) begin
				// hold the current word until accepted
			end else if (pending_cmds.size() != 0 && !hold_sender
			             && $urandom_range(0, 99) >= gap_pct) begin
				start <= 1'b1;
				cmd   <= pending_cmds[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every done strobe is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result word %p", result);
			end else begin
				isim_pkg::result_t exp_r;
				exp_r = expected_results.pop_front();
				if (result.merged_start !== exp_r.merged_start
				    || result.merged_end !== exp_r.merged_end
				    || result.entry_total !== exp_r.entry_total
				    || result.window_covered !== exp_r.window_covered
				    || result.overflow !== exp_r.overflow) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: expected %p, got %p", exp_r, result);
				end
			end
		end
	end

	// Wait until every queued word has gone and every result has come back
	task automatic drain();
		while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [isim_pkg::CFG_IDX_W-1:0] idx, isim_pkg::time_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == isim_pkg::REG_QUERY_START)
			win_start = value;
		else
			win_end = value;
	endtask

	task automatic run_random(int count);
		int n;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 3)
				queue_cmd(make_clear());
			else
				queue_cmd(random_insert());
		end
	endtask

	initial begin
		int i;
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		shadow_count   = 0;
		shadow_covered = 1'b0;
		win_start      = '0;
		win_end        = '0;
		mismatch_count = 0;
		gap_pct        = 21;
		hold_sender    = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(isim_pkg::REG_QUERY_START, 31'd100);
		write_reg(isim_pkg::REG_QUERY_END, 31'd200);

		// Directed: append, place in front, touching neighbours, merge run
		queue_cmd(make_insert(31'd300, 31'd400));
		queue_cmd(make_insert(31'd10, 31'd20));
		queue_cmd(make_insert(31'd21, 31'd30));
		queue_cmd(make_insert(31'd401, 31'd500));
		queue_cmd(make_insert(31'd25, 31'd450));
		queue_cmd(make_insert(31'd600, 31'd550));
		queue_cmd(make_insert(31'd0, 31'd0));
		queue_cmd(make_insert(31'h7FFFFFFF, 31'h7FFFFFFF));
		queue_cmd(make_insert(31'd0, 31'h7FFFFFFF));
		queue_cmd(make_clear());
		queue_cmd(make_insert(31'h7FFFFFFE, 31'd5));
		queue_cmd(make_clear());
		// Fill the table, then overflow by placing and by appending, and merge into it when full
		for (i = 0; i < isim_pkg::MAX_INTERVALS; i++)
			queue_cmd(make_insert(isim_pkg::time_t'(10 + i * 10),
			                      isim_pkg::time_t'(14 + i * 10)));
		queue_cmd(make_insert(31'd1, 31'd2));
		queue_cmd(make_insert(31'd5000, 31'd6000));
		queue_cmd(make_insert(31'd12, 31'd200));
		drain();

		// Pause the sender with a clear pending, then release it
		hold_sender = 1'b1;
		queue_cmd(make_clear());
		repeat (20) @(posedge clk);
		hold_sender = 1'b0;
		drain();

		write_reg(isim_pkg::REG_QUERY_START, 31'd1000);
		write_reg(isim_pkg::REG_QUERY_END, 31'd1040);
		run_random(130);
		drain();

		gap_pct = 68;
		write_reg(isim_pkg::REG_QUERY_START, 31'h7FFFFFFF);
		write_reg(isim_pkg::REG_QUERY_END, 31'd0);
		run_random(130);
		drain();

		gap_pct = 0;
		write_reg(isim_pkg::REG_QUERY_START, 31'd0);
		write_reg(isim_pkg::REG_QUERY_END, 31'h7FFFFFFF);
		run_random(70);
		drain();
		write_reg(isim_pkg::REG_QUERY_START, isim_pkg::time_t'($urandom_range(0, 3000)));
		write_reg(isim_pkg::REG_QUERY_END, isim_pkg::time_t'($urandom_range(0, 3000)));
		run_random(70);
		drain();
		repeat (3 * isim_pkg::MAX_INTERVALS + 20) @(posedge clk);

		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// File: files.f
design/isim_pkg.sv
design/isim_ram.sv
design/isim_core.sv
design/interval_set_insert_merge.sv
tb/tb_interval_set_insert_merge.sv
